### rtl/lapet_pkg.sv
// Shared constants, register codes and types of the Laplacian edge threshold block.
package lapet_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int PIXEL_BITS = 8;

  // Fixed field widths of the register file and result port
  localparam int DIM_BITS     = 12;
  localparam int COEF_BITS    = 5;
  localparam int THR_BITS     = 8;
  localparam int POS_BITS     = 11;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 12;

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WID_BITS = (DIM_BITS > COL_BITS + 1) ? DIM_BITS : COL_BITS + 1;
  localparam int HGT_BITS = (DIM_BITS > ROW_BITS + 1) ? DIM_BITS : ROW_BITS + 1;
  localparam int SUM_BITS = PIXEL_BITS + 9;
  localparam int CMP_BITS = (PIXEL_BITS > THR_BITS) ? PIXEL_BITS : THR_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_LEFT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_CENTER    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_RIGHT     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOTTOM    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THRESHOLD = 3'd7;

  // Result slots of one pixel, in emission order
  localparam int NUM_RES    = 3;
  localparam int RES_UP     = 0;  // row above, same column
  localparam int RES_LEFT   = 1;  // last row, column to the left
  localparam int RES_CORNER = 2;  // last row, last column

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam coef_t COEF_SIDE_RST   = -5'sd1;
  localparam coef_t COEF_CENTER_RST = 5'sd4;
  localparam logic [THR_BITS-1:0] EDGE_THRESHOLD_RST = 8'd26;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    coef_t               coef_top;
    coef_t               coef_left;
    coef_t               coef_center;
    coef_t               coef_right;
    coef_t               coef_bottom;
    logic [THR_BITS-1:0] edge_threshold;
  } cfg_t;

  typedef struct packed {
    pix_t top;
    pix_t left;
    pix_t center;
    pix_t right;
    pix_t bottom;
  } stencil_ops_t;

  typedef struct packed {
    stencil_ops_t [NUM_RES-1:0] ops;
    logic [NUM_RES-1:0]         pending;
    logic                       use_upr;
    logic [ROW_BITS-1:0]        row;
    logic [COL_BITS-1:0]        col;
  } work_item_t;

endpackage

### rtl/laplacian_edge_threshold.sv
// Top level of the streaming Laplacian edge detector with threshold.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_stall    gray_level
//   out      out        out_valid / out_stall  edge_bit, out_row, out_col, run_last
//
// One pixel per clock is taken while its results fit through the single output register,
// which passes one result beat per cycle while not stalled: row 0 gives none unless it
// is the last row, rows 1 to last-but-one one per pixel, the last row up to two per
// pixel and up to three on its last pixel; each result beyond the first holds the input
// back. A pixel's results pass the work register, then the output register. Synchronous
// reset clears counters and handshake state; line stores are not cleared and need no
// startup pass. in_stall is high while more results wait; on the last it tracks out_stall.
module laplacian_edge_threshold (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lapet_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lapet_pkg::CFG_DAT_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lapet_pkg::PIXEL_BITS-1:0]   gray_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               edge_bit,
  output logic [lapet_pkg::POS_BITS-1:0]     out_row,
  output logic [lapet_pkg::POS_BITS-1:0]     out_col,
  output logic                               run_last
);
  import lapet_pkg::*;

  cfg_t       cfg;
  work_item_t item;
  pix_t       above_right;
  logic       accept, in_free;

  assign in_stall = !in_free;
  assign accept   = in_valid && !in_stall;

  lapet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lapet_window u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .pixel       (gray_level),
    .item        (item),
    .above_right (above_right)
  );

  lapet_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .item_in     (item),
    .above_right (above_right),
    .in_free     (in_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .edge_bit    (edge_bit),
    .out_row     (out_row),
    .out_col     (out_col),
    .run_last    (run_last)
  );

endmodule

### rtl/lapet_cfg.sv
// Configuration register file: frame size, stencil weights and threshold.
module lapet_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lapet_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lapet_pkg::CFG_DAT_BITS-1:0]  cfg_data,
  output lapet_pkg::cfg_t                     cfg
);
  import lapet_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= FRAME_WIDTH_RST;
      cfg.frame_height   <= FRAME_HEIGHT_RST;
      cfg.coef_top       <= COEF_SIDE_RST;
      cfg.coef_left      <= COEF_SIDE_RST;
      cfg.coef_center    <= COEF_CENTER_RST;
      cfg.coef_right     <= COEF_SIDE_RST;
      cfg.coef_bottom    <= COEF_SIDE_RST;
      cfg.edge_threshold <= EDGE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data[DIM_BITS-1:0];
        REG_COEF_TOP:       cfg.coef_top       <= cfg_data[COEF_BITS-1:0];
        REG_COEF_LEFT:      cfg.coef_left      <= cfg_data[COEF_BITS-1:0];
        REG_COEF_CENTER:    cfg.coef_center    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_RIGHT:     cfg.coef_right     <= cfg_data[COEF_BITS-1:0];
        REG_COEF_BOTTOM:    cfg.coef_bottom    <= cfg_data[COEF_BITS-1:0];
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/lapet_window.sv
// Raster position counters, two line stores with prefetch and the pixel window.
module lapet_window (
  input  logic                  clk,
  input  logic                  rst,
  input  lapet_pkg::cfg_t       cfg,
  input  logic                  accept,
  input  lapet_pkg::pix_t       pixel,
  output lapet_pkg::work_item_t item,
  output lapet_pkg::pix_t       above_right
);
  import lapet_pkg::*;

  logic [COL_BITS-1:0] col_count, col, col_next;
  logic [ROW_BITS-1:0] row_count, row, row_next;
  logic [WID_BITS-1:0] width_eff;
  logic [HGT_BITS-1:0] height_eff;
  logic                last_col, last_row;

  // above_q / two_above_q hold the store entries at the current column
  pix_t above_q, two_above_q;
  pix_t win_up_left, win_left, win_left2;
  pix_t up1, up2;

  pix_t above_mem     [MAX_WIDTH];
  pix_t two_above_mem [MAX_WIDTH];

  always_comb begin
    if (cfg.frame_width == '0) begin
      width_eff = WID_BITS'(1);
    end else if (WID_BITS'(cfg.frame_width) > WID_BITS'(MAX_WIDTH)) begin
      width_eff = WID_BITS'(MAX_WIDTH);
    end else begin
      width_eff = WID_BITS'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      height_eff = HGT_BITS'(1);
    end else if (HGT_BITS'(cfg.frame_height) > HGT_BITS'(MAX_HEIGHT)) begin
      height_eff = HGT_BITS'(MAX_HEIGHT);
    end else begin
      height_eff = HGT_BITS'(cfg.frame_height);
    end

    // Saturate a position left beyond a shrunk frame
    col = (WID_BITS'(col_count) < width_eff) ? col_count
                                             : COL_BITS'(width_eff - WID_BITS'(1));
    row = (HGT_BITS'(row_count) < height_eff) ? row_count
                                              : ROW_BITS'(height_eff - HGT_BITS'(1));
    last_col = (WID_BITS'(col) == width_eff - WID_BITS'(1));
    last_row = (HGT_BITS'(row) == height_eff - HGT_BITS'(1));

    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + ROW_BITS'(1);
    end else begin
      col_next = col + COL_BITS'(1);
      row_next = row;
    end
  end

  assign up1         = above_q;
  assign up2         = two_above_q;
  assign above_right = above_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // Read ahead at the next column; forward the write when it is the same entry
  always_ff @(posedge clk) begin
    if (accept) begin
      above_mem[col]     <= pixel;
      two_above_mem[col] <= up1;
      if (col_next == col) begin
        above_q     <= pixel;
        two_above_q <= up1;
      end else begin
        above_q     <= above_mem[col_next];
        two_above_q <= two_above_mem[col_next];
      end
      win_up_left <= up1;
      win_left2   <= win_left;
      win_left    <= pixel;
    end
  end

  always_comb begin
    item     = '0;
    item.row = row;
    item.col = col;
    item.use_upr = !last_col;

    item.pending[RES_UP]     = (row != '0);
    item.pending[RES_LEFT]   = last_row && (col != '0);
    item.pending[RES_CORNER] = last_row && last_col;

    // Missing neighbors fall back to the center pixel; right of RES_UP is patched later
    item.ops[RES_UP].top    = (row > ROW_BITS'(1)) ? up2 : up1;
    item.ops[RES_UP].left   = (col != '0) ? win_up_left : up1;
    item.ops[RES_UP].center = up1;
    item.ops[RES_UP].right  = up1;
    item.ops[RES_UP].bottom = pixel;

    item.ops[RES_LEFT].top    = (row != '0) ? win_up_left : win_left;
    item.ops[RES_LEFT].left   = (col > COL_BITS'(1)) ? win_left2 : win_left;
    item.ops[RES_LEFT].center = win_left;
    item.ops[RES_LEFT].right  = pixel;
    item.ops[RES_LEFT].bottom = win_left;

    item.ops[RES_CORNER].top    = (row != '0) ? up1 : pixel;
    item.ops[RES_CORNER].left   = (col != '0) ? win_left : pixel;
    item.ops[RES_CORNER].center = pixel;
    item.ops[RES_CORNER].right  = pixel;
    item.ops[RES_CORNER].bottom = pixel;
  end

endmodule

### rtl/lapet_stencil.sv
// Five-point weighted sum, clamp to pixel range and threshold compare.
module lapet_stencil (
  input  lapet_pkg::cfg_t         cfg,
  input  lapet_pkg::stencil_ops_t ops,
  output logic                    edge_bit
);
  import lapet_pkg::*;

  localparam logic signed [SUM_BITS-1:0] PIX_TOP = SUM_BITS'((1 << PIXEL_BITS) - 1);

  logic signed [SUM_BITS-1:0] sum;
  logic [PIXEL_BITS-1:0]      clamped;

  function automatic logic signed [SUM_BITS-1:0] weigh(pix_t px, coef_t k);
    logic signed [SUM_BITS-1:0] px_s;
    logic signed [SUM_BITS-1:0] k_s;
    px_s = {{(SUM_BITS-PIXEL_BITS){1'b0}}, px};
    k_s  = {{(SUM_BITS-COEF_BITS){k[COEF_BITS-1]}}, k};
    return px_s * k_s;
  endfunction

  always_comb begin
    sum = weigh(ops.top, cfg.coef_top) + weigh(ops.left, cfg.coef_left)
        + weigh(ops.center, cfg.coef_center) + weigh(ops.right, cfg.coef_right)
        + weigh(ops.bottom, cfg.coef_bottom);
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > PIX_TOP) begin
      clamped = '1;
    end else begin
      clamped = sum[PIXEL_BITS-1:0];
    end
    edge_bit = (CMP_BITS'(clamped) > CMP_BITS'(cfg.edge_threshold));
  end

endmodule

### rtl/lapet_emit.sv
// Work register that hands out a pixel's results one beat at a time into the output register.
module lapet_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  lapet_pkg::cfg_t              cfg,
  input  logic                         accept,
  input  lapet_pkg::work_item_t        item_in,
  input  lapet_pkg::pix_t              above_right,
  output logic                         in_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         edge_bit,
  output logic [lapet_pkg::POS_BITS-1:0] out_row,
  output logic [lapet_pkg::POS_BITS-1:0] out_col,
  output logic                         run_last
);
  import lapet_pkg::*;

  work_item_t         item;
  logic               busy;
  logic [NUM_RES-1:0] pick;
  logic               last_pick, issue, edge_now;
  stencil_ops_t       ops;
  logic [POS_BITS-1:0] row_now, col_now;

  // Lowest pending slot goes next
  assign pick      = item.pending & (~item.pending + NUM_RES'(1));
  assign last_pick = (item.pending & ~pick) == '0;
  assign issue     = busy && (!out_valid || !out_stall);
  assign in_free   = !busy || (issue && last_pick);

  always_comb begin
    if (pick[RES_UP]) begin
      ops = item.ops[RES_UP];
      if (item.use_upr) begin
        ops.right = above_right;
      end
      row_now = POS_BITS'(item.row - ROW_BITS'(1));
      col_now = POS_BITS'(item.col);
    end else if (pick[RES_LEFT]) begin
      ops     = item.ops[RES_LEFT];
      row_now = POS_BITS'(item.row);
      col_now = POS_BITS'(item.col - COL_BITS'(1));
    end else begin
      ops     = item.ops[RES_CORNER];
      row_now = POS_BITS'(item.row);
      col_now = POS_BITS'(item.col);
    end
  end

  lapet_stencil u_stencil (
    .cfg      (cfg),
    .ops      (ops),
    .edge_bit (edge_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= (item_in.pending != '0);
      end else if (issue && last_pick) begin
        busy <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end else if (issue) begin
      item.pending <= item.pending & ~pick;
    end
    if (issue) begin
      edge_bit <= edge_now;
      out_row  <= row_now;
      out_col  <= col_now;
      run_last <= last_pick;
    end
  end

endmodule

### rtl/lapet_checker.sv
// Port-level checks of the edge detector, bound to the top level.
module lapet_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           edge_bit,
  input logic [lapet_pkg::POS_BITS-1:0] out_row,
  input logic [lapet_pkg::POS_BITS-1:0] out_col,
  input logic                           run_last
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edge_bit) && $stable(out_row)
                               && $stable(out_col) && $stable(run_last))
    else $error("stalled result beat changed");

  // Results of one pixel leave back to back
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a pixel's result run");

  // Within a run the next result is one row down or one column right
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=>
      (out_row == $past(out_row) + 11'd1) || (out_col == $past(out_col) + 11'd1))
    else $error("unexpected position step inside a result run");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind laplacian_edge_threshold lapet_checker u_lapet_checker (.*);
